// File: sv/json_string_escaper_core_macros.svh
// Assertion macros used by the checker file of the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_CORE_MACROS_SVH
`define JSON_STRING_ESCAPER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/jse_pkg.sv
// Package: types, character codes and helpers of the JSON string escaper.
package jse_pkg;

  // Default depth of the queue between the decoder and the expander
  localparam int JSE_QDEPTH = 4;

  // Input operation codes
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Register index of pass_utf8
  localparam logic REG_PASS_UTF8 = 1'b0;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Kind of work handed from the decoder to the expander
  typedef enum logic [2:0] {
    JOB_CHAR = 3'd0,  // one plain byte
    JOB_ESC  = 3'd1,  // backslash and one byte
    JOB_U4   = 3'd2,  // \uXXXX of u0
    JOB_PAIR = 3'd3,  // \uXXXX of u0 then \uXXXX of u1
    JOB_ERR  = 3'd4   // single error result
  } jse_kind_t;

  typedef struct packed {
    jse_kind_t   kind;
    logic [15:0] u0;
    logic [15:0] u1;
  } jse_job_t;

  // Lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

  // Number of output characters of a job
  function automatic logic [3:0] job_len(input jse_kind_t kind);
    logic [3:0] n;
    case (kind)
      JOB_CHAR: n = 4'd1;
      JOB_ESC:  n = 4'd2;
      JOB_U4:   n = 4'd6;
      JOB_PAIR: n = 4'd12;
      JOB_ERR:  n = 4'd1;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// File: sv/jse_fifo.sv
// Job queue between the decoder front end and the character expander.
module jse_fifo
  import jse_pkg::*;
#(
  parameter int DEPTH = JSE_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jse_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output jse_job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jse_job_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: sv/jse_front.sv
// Front end: accepts items, runs the UTF-8 decoder and turns each whole character, marker or error into a job.
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pass_utf8,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       push,
  output jse_job_t   push_job
);

  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  seqlen_r, seqlen_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic        accept;
  logic [20:0] cp_ext;
  logic [20:0] sp;
  logic [7:0]  esc_ch;

  assign accept = in_valid && !q_full;
  // Code point with this continuation byte shifted in, and its supplementary offset
  assign cp_ext = {cp_r[14:0], in_data_byte[5:0]};
  assign sp     = cp_ext - 21'h010000;

  // Two-character escape partner; zero when the byte passes as is
  always_comb begin
    case (in_data_byte)
      CH_QUOTE:  esc_ch = CH_QUOTE;
      CH_BSLASH: esc_ch = CH_BSLASH;
      CH_SLASH:  esc_ch = CH_SLASH;
      CH_BS:     esc_ch = CH_LOW_B;
      CH_FF:     esc_ch = CH_LOW_F;
      CH_LF:     esc_ch = CH_LOW_N;
      CH_CR:     esc_ch = CH_LOW_R;
      CH_TAB:    esc_ch = CH_LOW_T;
      default:   esc_ch = 8'h00;
    endcase
  end

  // Decode and classify
  always_comb begin
    pend_nxt   = pend_r;
    seqlen_nxt = seqlen_r;
    cp_nxt     = cp_r;
    push       = 1'b0;
    push_job   = '{kind: JOB_CHAR, u0: 16'h0000, u1: 16'h0000};
    if (accept) begin
      case (in_op)
        OP_DATA: begin
          if (pend_r != 2'd0) begin
            push = (pend_r == 2'd1) || (in_data_byte[7:6] != 2'b10);
            if (in_data_byte[7:6] != 2'b10) begin
              // bad continuation byte
              push_job.kind = JOB_ERR;
              pend_nxt      = 2'd0;
              seqlen_nxt    = 2'd0;
              cp_nxt        = '0;
            end else if (pend_r != 2'd1) begin
              cp_nxt   = cp_ext;
              pend_nxt = pend_r - 2'd1;
            end else begin
              // sequence complete
              pend_nxt   = 2'd0;
              seqlen_nxt = 2'd0;
              cp_nxt     = '0;
              if (seqlen_r == 2'd3) begin
                if (cp_ext[20:16] == 5'd0 || sp[20]) begin
                  push_job.kind = JOB_ERR;
                end else begin
                  push_job.kind = JOB_PAIR;
                  push_job.u0   = {6'b110110, sp[19:10]};
                  push_job.u1   = {6'b110111, sp[9:0]};
                end
              end else if (seqlen_r == 2'd2 && cp_ext[15:11] == 5'b11011) begin
                // surrogate code point
                push_job.kind = JOB_ERR;
              end else begin
                push_job.kind = JOB_U4;
                push_job.u0   = cp_ext[15:0];
              end
            end
          end else if (pass_utf8 || !in_data_byte[7]) begin
            push = 1'b1;
            if (esc_ch != 8'h00) begin
              push_job.kind = JOB_ESC;
              push_job.u0   = {8'h00, esc_ch};
            end else begin
              push_job.u0   = {8'h00, in_data_byte};
            end
          end else if (in_data_byte[7:5] == 3'b110) begin
            if (in_data_byte[4:1] == 4'd0) begin
              // overlong two-byte lead
              push          = 1'b1;
              push_job.kind = JOB_ERR;
            end else begin
              cp_nxt     = {16'd0, in_data_byte[4:0]};
              seqlen_nxt = 2'd1;
              pend_nxt   = 2'd1;
            end
          end else if (in_data_byte[7:4] == 4'b1110) begin
            cp_nxt     = {17'd0, in_data_byte[3:0]};
            seqlen_nxt = 2'd2;
            pend_nxt   = 2'd2;
          end else if (in_data_byte[7:3] == 5'b11110) begin
            cp_nxt     = {18'd0, in_data_byte[2:0]};
            seqlen_nxt = 2'd3;
            pend_nxt   = 2'd3;
          end else begin
            // bad lead byte
            push          = 1'b1;
            push_job.kind = JOB_ERR;
          end
        end
        OP_BEGIN: begin
          push        = 1'b1;
          push_job.u0 = {8'h00, CH_QUOTE};
          pend_nxt    = 2'd0;
          seqlen_nxt  = 2'd0;
          cp_nxt      = '0;
        end
        OP_END: begin
          push = 1'b1;
          if (pend_r != 2'd0) begin
            // truncated sequence at end of string
            push_job.kind = JOB_ERR;
            pend_nxt      = 2'd0;
            seqlen_nxt    = 2'd0;
            cp_nxt        = '0;
          end else begin
            push_job.u0 = {8'h00, CH_QUOTE};
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      seqlen_r <= 2'd0;
      cp_r     <= '0;
    end else begin
      pend_r   <= pend_nxt;
      seqlen_r <= seqlen_nxt;
      cp_r     <= cp_nxt;
    end
  end

endmodule

// File: sv/jse_back.sv
// Back end: expands the head job into the output register, one character per cycle unless stalled.
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  jse_job_t   head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_bad_input
);

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        last_r, last_nxt;
  logic        bad_r, bad_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        advance;
  logic        second;
  logic [15:0] unit;
  logic [3:0]  pos;
  logic [3:0]  len;
  logic        is_last;
  logic [7:0]  ch;
  logic        ch_bad;

  assign advance = !out_valid_r || !out_stall;
  assign second  = (idx_r >= 4'd6);
  assign unit    = second ? head_job.u1 : head_job.u0;
  assign pos     = second ? (idx_r - 4'd6) : idx_r;
  assign len     = job_len(head_job.kind);
  assign is_last = (idx_r == (len - 4'd1));
  assign pop     = advance && head_valid && is_last;

  // Character at the current position of the head job
  always_comb begin
    ch     = 8'h00;
    ch_bad = 1'b0;
    case (head_job.kind)
      JOB_CHAR: ch = head_job.u0[7:0];
      JOB_ESC:  ch = (idx_r == 4'd0) ? CH_BSLASH : head_job.u0[7:0];
      JOB_ERR:  ch_bad = 1'b1;
      JOB_U4, JOB_PAIR: begin
        case (pos)
          4'd0:    ch = CH_BSLASH;
          4'd1:    ch = CH_LOW_U;
          4'd2:    ch = hex_char(unit[15:12]);
          4'd3:    ch = hex_char(unit[11:8]);
          4'd4:    ch = hex_char(unit[7:4]);
          4'd5:    ch = hex_char(unit[3:0]);
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
  end

  // Output register and position counter
  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    bad_nxt       = bad_r;
    idx_nxt       = idx_r;
    if (advance) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        char_nxt = ch;
        last_nxt = is_last;
        bad_nxt  = ch_bad;
        idx_nxt  = is_last ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = char_r;
  assign out_last_of_run = last_r;
  assign out_bad_input   = bad_r;

endmodule

// File: sv/json_string_escaper_core.sv
// Path: an accepted item is written into the job queue; its characters then pass through the output register.
// Throughput: unless stalled, one input item per cycle while each item yields one character; the
// expander sends one character per cycle unless stalled; escapes yield 2, \u forms 6, surrogate pairs 12 characters.
// The job queue (QDEPTH entries) lets the decoder run ahead of the expander.
// Reset (synchronous, rst_n low): decoder state, queue and output valid clear; pass_utf8 = 1.
module json_string_escaper_core
  import jse_pkg::*;
#(
  parameter int QDEPTH = JSE_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic        out_bad_input,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     pass_utf8_r, pass_utf8_nxt;
  logic     q_full;
  logic     push;
  jse_job_t push_job;
  logic     pop;
  logic     head_valid;
  jse_job_t head_job;

  // Configuration register
  assign pready = 1'b1;
  always_comb begin
    pass_utf8_nxt = pass_utf8_r;
    if (psel && penable && pwrite && (paddr[2] == REG_PASS_UTF8)) begin
      pass_utf8_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_utf8_r <= 1'b1;
    end else begin
      pass_utf8_r <= pass_utf8_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_PASS_UTF8) ? {31'd0, pass_utf8_r} : 32'd0;

  assign in_stall = q_full;

  jse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .pass_utf8    (pass_utf8_r),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  jse_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_bad_input   (out_bad_input)
  );

endmodule

// File: sv/jse_checker.sv
// Port-level checker for the JSON string escaper, bound to the top level.
`include "json_string_escaper_core_macros.svh"

module jse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_op,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        out_last_of_run,
  input logic        out_bad_input,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic [9:0] in_word;
  logic [9:0] out_word;
  logic       cfg_wr;

  // Payload of each channel and the register write strobe
  assign in_word  = {in_op, in_data_byte};
  assign out_word = {out_char, out_last_of_run, out_bad_input};
  assign cfg_wr   = psel && penable && pwrite && pready;

  // An error result is a lone zero character that closes its run
  `JSE_ASSERT_NOW(a_err_shape, out_valid && out_bad_input, out_word == 10'b11, "bad error result")

  // A stalled result holds
  `JSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result moved")

  // A stalled input transfer holds
  `JSE_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word), "input moved")

  // pass_utf8 reads back what was written
  `JSE_ASSERT_NEXT(a_cfg_readback, cfg_wr && !paddr[2], paddr[2] || prdata[0] == $past(pwdata[0]), "bad readback")

  // Unused register bits read as zero
  `JSE_ASSERT_NOW(a_cfg_upper_zero, 1'b1, prdata[31:1] == 31'd0, "upper read bits set")

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (.*);
